FILE: hw/rtl/hcq_pkg.sv
// ----------------------------------------------------------------------------
// hcq_pkg: shared types and constants for the bisulfite hit QC filter
// Holds CIGAR and strand codes, the hit record that crosses from the front
// end to the back end, register indexes and default sizes.
// ----------------------------------------------------------------------------
package hcq_pkg;

    localparam int CIGAR_LEN_W    = 28;
    localparam int CIGAR_CODE_W   = 4;
    localparam int READ_LEN_W     = 24;
    localparam int MAPQ_W         = 8;
    localparam int STRAND_W       = 2;
    localparam int PCT_W          = 7;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 7;

    localparam int S_TDATA_W      = 72;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 16;

    localparam int DEF_READ_LEN_BITS = 24;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Scale applied to the longest run before comparing with percent * length
    localparam int RUN_SCALE      = 100;

    localparam logic [CIGAR_CODE_W-1:0] CIGAR_MATCH = 4'd0;
    localparam logic [CIGAR_CODE_W-1:0] CIGAR_EQUAL = 4'd7;
    localparam logic [CIGAR_CODE_W-1:0] CIGAR_DIFF  = 4'd8;

    localparam logic [STRAND_W-1:0] STRAND_NONE = 2'd0;
    localparam logic [STRAND_W-1:0] STRAND_FWD  = 2'd1;
    localparam logic [STRAND_W-1:0] STRAND_REV  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_FORCED_FAIL_STRAND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHIMERA_CHECK_ON   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_MATCH_PERCENT  = 2'd2;

    localparam logic [MAPQ_W-1:0] MAPQ_CLAMP = 8'd1;

    // One finished hit, as handed from the front end to the back end
    typedef struct packed {
        logic [CIGAR_LEN_W-1:0] longest_run;
        logic                   ops_seen;
        logic [STRAND_W-1:0]    strand;
        logic                   primary;
        logic [READ_LEN_W-1:0]  read_len;
        logic [MAPQ_W-1:0]      mapq;
        logic                   last_hit;
    } hcq_hit_t;

    function automatic logic is_match_op(input logic [CIGAR_CODE_W-1:0] code);
        return (code == CIGAR_MATCH) || (code == CIGAR_EQUAL) || (code == CIGAR_DIFF);
    endfunction

endpackage

FILE: hw/rtl/bisulfite_hit_qc_filter.sv
// Throughput: one operation transaction per cycle while the queue is not full;
// one result per cycle downstream while m_tready accepts it.
// The rate is set by the run tracker in the front end and the
// two-stage product/compare pipe in the back end, coupled by a 4-entry queue.
// Reset: rst_n clears run tracking, queue, pipe and group accumulator at once;
// configuration returns to strand none, chimera test on, 44 percent.
// ----------------------------------------------------------------------------
// bisulfite_hit_qc_filter: top level
// Per-hit QC on a stream of CIGAR operations with forced-strand and chimera
// tests and a read-group failure flag.
// ----------------------------------------------------------------------------
module bisulfite_hit_qc_filter
    import hcq_pkg::*;
#(
    parameter int READ_LEN_BITS = DEF_READ_LEN_BITS,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cigar_code[3:0], cigar_len[31:4], contig_strand[33:32], is_primary[34],
    // read_len[58:35], mapq_in[66:59], zero[71:67]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // op_present[0], last_hit_of_group[1]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit_failed[0], mapq_out[8:1], group_failed[9], zero[15:10]
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    hcq_hit_t push_data;
    hcq_hit_t pop_data;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    hcq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_data   (push_data)
    );

    hcq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    hcq_back #(
        .READ_LEN_BITS (READ_LEN_BITS)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_empty   (empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: hw/rtl/hcq_front.sv
// ----------------------------------------------------------------------------
// hcq_front: CIGAR operation intake
// Accepts operation transactions, keeps the longest M/=/X run of the hit
// and pushes one hit record into the queue on the hit's last operation.
// ----------------------------------------------------------------------------
module hcq_front
    import hcq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,
    input  logic [S_TUSER_W-1:0]    s_tuser,
    input  logic                    s_tlast,
    input  logic                    q_full,
    output logic                    q_push,
    output hcq_hit_t                q_data
);

    logic [CIGAR_LEN_W-1:0]  run_reg;
    logic [CIGAR_LEN_W-1:0]  run_next;
    logic                    ops_reg;
    logic                    ops_next;

    logic                    accept;
    logic                    op_present;
    logic [CIGAR_CODE_W-1:0] cigar_code;
    logic [CIGAR_LEN_W-1:0]  cigar_len;
    logic [CIGAR_LEN_W-1:0]  run_now;
    logic                    ops_now;

    assign op_present = s_tuser[0];
    assign cigar_code = s_tdata[3:0];
    assign cigar_len  = s_tdata[31:4];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        run_now = run_reg;
        if (op_present && is_match_op(cigar_code) && (cigar_len > run_reg))
        begin
            run_now = cigar_len;
        end
        ops_now = ops_reg || op_present;
    end

    always_comb
    begin
        run_next = run_reg;
        ops_next = ops_reg;
        if (accept)
        begin
            // clear per-hit tracking at the hit's last operation
            run_next = s_tlast ? '0 : run_now;
            ops_next = s_tlast ? 1'b0 : ops_now;
        end
    end

    assign q_push               = accept && s_tlast;
    assign q_data.longest_run   = run_now;
    assign q_data.ops_seen      = ops_now;
    assign q_data.strand        = s_tdata[33:32];
    assign q_data.primary       = s_tdata[34];
    assign q_data.read_len      = s_tdata[58:35];
    assign q_data.mapq          = s_tdata[66:59];
    assign q_data.last_hit      = s_tuser[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            ops_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            ops_reg <= ops_next;
        end
    end

endmodule

FILE: hw/rtl/hcq_queue.sv
// ----------------------------------------------------------------------------
// hcq_queue: hit record queue
// Short first-in first-out store that decouples intake from judgment.
// ----------------------------------------------------------------------------
module hcq_queue
    import hcq_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  hcq_hit_t push_data,
    input  logic     pop,
    output hcq_hit_t pop_data,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    hcq_hit_t             mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/hcq_back.sv
// ----------------------------------------------------------------------------
// hcq_back: hit judgment
// Holds the configuration registers, forms the chimera products in one
// stage, compares and accumulates the group failure in the next, and drives
// the result stream from an output register.
// ----------------------------------------------------------------------------
module hcq_back
    import hcq_pkg::*;
#(
    parameter int READ_LEN_BITS = DEF_READ_LEN_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   q_empty,
    input  hcq_hit_t               q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,
    output logic                   m_tlast
);

    localparam int RL_W  = (READ_LEN_BITS < READ_LEN_W) ? READ_LEN_BITS : READ_LEN_W;
    localparam int LHS_W = CIGAR_LEN_W + PCT_W;
    localparam int RHS_W = RL_W + PCT_W;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    // configuration
    logic [STRAND_W-1:0]  ffs_reg;
    logic                 chk_reg;
    logic [PCT_W-1:0]     pct_reg;

    // product stage
    logic                 a_valid_reg;
    logic                 a_valid_next;
    logic [LHS_W-1:0]     a_lhs_reg;
    logic [RHS_W-1:0]     a_rhs_reg;
    logic                 a_forced_reg;
    logic                 a_chim_en_reg;
    logic [MAPQ_W-1:0]    a_mapq_reg;
    logic                 a_last_reg;

    // output stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_failed_reg;
    logic [MAPQ_W-1:0]    out_mapq_reg;
    logic                 out_group_reg;
    logic                 out_last_reg;
    logic                 acc_reg;
    logic                 acc_next;

    logic                 out_free;
    logic                 a_free;
    logic                 a_move;
    logic [RL_W-1:0]      rlen;
    logic                 judged;
    logic                 forced;
    logic                 chim_en;
    logic                 chim_fail;
    logic                 failed;
    logic                 acc_now;
    logic [MAPQ_W-1:0]    mapq_res;

    assign out_free = !out_valid_reg || m_tready;
    assign a_move   = a_valid_reg && out_free;
    assign a_free   = !a_valid_reg || out_free;
    assign q_pop    = a_free && !q_empty;

    assign rlen    = q_data.read_len[RL_W-1:0];
    assign judged  = q_data.primary
                     && ((q_data.strand == STRAND_FWD) || (q_data.strand == STRAND_REV));
    assign forced  = judged && (ffs_reg != STRAND_NONE) && (ffs_reg == q_data.strand);
    assign chim_en = judged && chk_reg && q_data.ops_seen && (rlen != '0);

    assign chim_fail = a_chim_en_reg && (CMP_W'(a_lhs_reg) < CMP_W'(a_rhs_reg));
    assign failed    = a_forced_reg || chim_fail;
    assign mapq_res  = (chim_fail && (a_mapq_reg > MAPQ_CLAMP)) ? MAPQ_CLAMP : a_mapq_reg;
    assign acc_now   = acc_reg || failed;

    always_comb
    begin
        a_valid_next   = a_valid_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        if (a_free)
        begin
            a_valid_next = !q_empty;
        end
        if (out_free)
        begin
            out_valid_next = a_valid_reg;
        end
        if (a_move)
        begin
            // clear the group accumulator after the group's last hit
            acc_next = a_last_reg ? 1'b0 : acc_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            a_lhs_reg     <= LHS_W'(q_data.longest_run) * LHS_W'(RUN_SCALE);
            a_rhs_reg     <= RHS_W'(pct_reg) * RHS_W'(rlen);
            a_forced_reg  <= forced;
            a_chim_en_reg <= chim_en;
            a_mapq_reg    <= q_data.mapq;
            a_last_reg    <= q_data.last_hit;
        end
        if (a_move)
        begin
            out_failed_reg <= failed;
            out_mapq_reg   <= mapq_res;
            out_group_reg  <= a_last_reg && acc_now;
            out_last_reg   <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ffs_reg       <= STRAND_NONE;
            chk_reg       <= 1'b1;
            pct_reg       <= PCT_W'(44);
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_FORCED_FAIL_STRAND: ffs_reg <= cfg_wdata[STRAND_W-1:0];
                    REG_CHIMERA_CHECK_ON:   chk_reg <= cfg_wdata[0];
                    REG_MIN_MATCH_PERCENT:  pct_reg <= cfg_wdata[PCT_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_group_reg, out_mapq_reg, out_failed_reg};

endmodule
